FILE: sv/emadl_pkg.sv
// Shared types, widths, register codes and reset values of the distance linearizer.
package emadl_pkg;

	localparam int SAMPLE_W = 10;
	localparam int ALPHA_W  = 16;
	localparam int SCALE_W  = 32;
	localparam int LEVEL_W  = 26;
	localparam int DIST_W   = 16;
	localparam int FRAC_W   = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Dividend is the scale moved up by the Q8.8 output fraction.
	localparam int DIST_FRAC_W = 8;
	localparam int DIVIDEND_W  = SCALE_W + DIST_FRAC_W;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ALPHA        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_SCALE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_OFFSET  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_SCALE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_OFFSET = 3'd4;

	localparam logic [ALPHA_W-1:0] ALPHA_RST        = 16'd1311;
	localparam logic [SCALE_W-1:0] LEFT_SCALE_RST   = 32'd182670328;
	localparam logic [LEVEL_W-1:0] LEFT_OFFSET_RST  = 26'd6294811;
	localparam logic [SCALE_W-1:0] RIGHT_SCALE_RST  = 32'd239578644;
	localparam logic [LEVEL_W-1:0] RIGHT_OFFSET_RST = 26'd4429185;

	typedef struct packed {
		logic [ALPHA_W-1:0] alpha;
		logic [SCALE_W-1:0] left_scale;
		logic [LEVEL_W-1:0] left_offset;
		logic [SCALE_W-1:0] right_scale;
		logic [LEVEL_W-1:0] right_offset;
	} cfg_t;

	// One classified item waiting for the divider.
	typedef struct packed {
		logic               side;
		logic               above;
		logic [LEVEL_W-1:0] diff;
		logic [SCALE_W-1:0] scale;
	} job_t;

endpackage

FILE: sv/emadl_front.sv
// Front end: accepts samples, updates the per-channel average and classifies the item.
module emadl_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  emadl_pkg::cfg_t                  cfg,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             side,
	input  logic [emadl_pkg::SAMPLE_W-1:0]   sample,
	output logic                             push,
	output emadl_pkg::job_t                  push_job,
	input  logic                             queue_full
);

	localparam int WEIGHT_W = emadl_pkg::ALPHA_W + 1;
	localparam int PROD_W   = emadl_pkg::LEVEL_W + WEIGHT_W;
	localparam int SPROD_W  = emadl_pkg::SAMPLE_W + emadl_pkg::ALPHA_W;
	localparam logic [WEIGHT_W-1:0] ONE = WEIGHT_W'(1) << emadl_pkg::FRAC_W;
	localparam logic [PROD_W-1:0]   HALF = PROD_W'(1) << (emadl_pkg::FRAC_W - 1);

	logic                              valid_s1, valid_s2;
	logic                              side_s1, side_s2;
	logic [emadl_pkg::SAMPLE_W-1:0]    sample_s1;
	logic [PROD_W-1:0]                 prod_lvl_s2;
	logic [SPROD_W-1:0]                prod_smp_s2;
	logic [emadl_pkg::LEVEL_W-1:0]     level_q [2];

	logic [WEIGHT_W-1:0]               keep_w;
	logic [PROD_W-1:0]                 acc;
	logic [emadl_pkg::LEVEL_W-1:0]     avg_new;
	logic [emadl_pkg::LEVEL_W-1:0]     offset;
	logic                              accept;

	assign in_stall = valid_s1 | valid_s2;
	assign accept   = in_valid & ~in_stall;
	assign keep_w   = ONE - {1'b0, cfg.alpha};

	assign acc = prod_lvl_s2 + PROD_W'({prod_smp_s2, {emadl_pkg::FRAC_W{1'b0}}}) + HALF;
	assign avg_new = acc[emadl_pkg::FRAC_W +: emadl_pkg::LEVEL_W];
	assign offset  = side_s2 ? cfg.right_offset : cfg.left_offset;

	assign push           = valid_s2 & ~queue_full;
	assign push_job.side  = side_s2;
	assign push_job.above = avg_new > offset;
	assign push_job.diff  = avg_new - offset;
	assign push_job.scale = side_s2 ? cfg.right_scale : cfg.left_scale;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			level_q[0] <= '0;
			level_q[1] <= '0;
		end else begin
			valid_s1 <= accept;
			if (valid_s1) begin
				valid_s2 <= 1'b1;
			end else if (push) begin
				valid_s2 <= 1'b0;
			end
			if (push) begin
				level_q[side_s2] <= avg_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			side_s1   <= side;
			sample_s1 <= sample;
		end
		if (valid_s1) begin
			side_s2     <= side_s1;
			prod_lvl_s2 <= level_q[side_s1] * keep_w;
			prod_smp_s2 <= sample_s1 * cfg.alpha;
		end
	end

endmodule

FILE: sv/emadl_queue.sv
// Short queue of classified items between the front end and the divider.
module emadl_queue #(
	parameter int DEPTH = emadl_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  emadl_pkg::job_t push_job,
	output logic            full,
	input  logic            pop,
	output emadl_pkg::job_t pop_job,
	output logic            empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	emadl_pkg::job_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = count_q == CNT_W'(DEPTH);
	assign empty   = count_q == '0;
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

FILE: sv/emadl_back.sv
// Back end: bit-serial restoring divide, saturation and the output register.
module emadl_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           queue_empty,
	input  emadl_pkg::job_t                pop_job,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           side_out,
	output logic [emadl_pkg::DIST_W-1:0]   distance,
	output logic                           valid_res,
	output logic                           saturated
);

	localparam int DQ_W  = emadl_pkg::DIVIDEND_W;
	localparam int REM_W = emadl_pkg::LEVEL_W;
	localparam int CNT_W = $clog2(DQ_W);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DQ_W - 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_OUT  = 3'b100
	} back_state_t;

	back_state_t              state_q;
	logic [CNT_W-1:0]         step_q;
	logic [DQ_W-1:0]          dq_q;
	logic [REM_W-1:0]         rem_q;
	logic [REM_W-1:0]         div_q;
	logic                     side_q;
	logic                     above_q;
	logic                     out_valid_q;

	logic [REM_W:0]           rem_sh;
	logic                     ge;
	logic [REM_W:0]           trial;
	logic                     load_out;
	logic                     sat;

	assign rem_sh   = {rem_q, dq_q[DQ_W-1]};
	assign ge       = rem_sh >= {1'b0, div_q};
	assign trial    = rem_sh - {1'b0, div_q};
	assign pop      = (state_q == ST_IDLE) & ~queue_empty;
	assign load_out = (state_q == ST_OUT) & (~out_valid_q | ~out_stall);
	assign sat      = |dq_q[DQ_W-1:emadl_pkg::DIST_W];
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						step_q  <= '0;
						state_q <= pop_job.above ? ST_DIV : ST_OUT;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			side_q  <= pop_job.side;
			above_q <= pop_job.above;
			div_q   <= pop_job.diff;
			rem_q   <= '0;
			// Below or at the offset the quotient reads as zero.
			dq_q    <= pop_job.above ? {pop_job.scale, emadl_pkg::DIST_FRAC_W'(0)} : '0;
		end else if (state_q == ST_DIV) begin
			rem_q <= ge ? trial[REM_W-1:0] : rem_sh[REM_W-1:0];
			dq_q  <= {dq_q[DQ_W-2:0], ge};
		end
		if (load_out) begin
			side_out  <= side_q;
			valid_res <= above_q;
			saturated <= sat;
			distance  <= sat ? '1 : dq_q[emadl_pkg::DIST_W-1:0];
		end
	end

endmodule

FILE: sv/ema_ir_distance_linearizer.sv
// Top level of the two-channel smoothed infrared distance linearizer.
//
// Each accepted item carries a 10-bit converter sample and a channel tag
// (left or right). The front end smooths the channel's level as an
// exponential moving average in Q10.16 counts, tests it against the channel
// offset and queues the difference; the back end divides (scale << 8) by
// that difference one quotient bit per cycle and returns the distance in
// Q8.8 centimetres, clipped to the maximum with a saturated flag, or zero
// with valid_res low when the level does not exceed the offset. The front
// end works on one item at a time (accept, multiply, update). The back end
// fetches an item, runs 40 divider steps when it needs a divide and loads
// the output register, so the 40-step divider sets the sustained rate.
// The queue lets the front end take new samples while the divider is busy
// and the output register lets a finished result wait for the sink.
// Registers are to be written only while the block is idle; the block
// itself does not enforce this. cfg_ready is always high and writes to
// unused indexes are dropped.
module ema_ir_distance_linearizer #(
	parameter int QUEUE_DEPTH = emadl_pkg::QUEUE_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// sample channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               side,
	input  logic [emadl_pkg::SAMPLE_W-1:0]     sample,
	// result channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               side_out,
	output logic [emadl_pkg::DIST_W-1:0]       distance,
	output logic                               valid_res,
	output logic                               saturated,
	// register write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [emadl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [emadl_pkg::CFG_DATA_W-1:0]   cfg_data
);

	emadl_pkg::cfg_t cfg_q;
	emadl_pkg::job_t push_job, pop_job;
	logic            push, pop, queue_full, queue_empty;

	assign cfg_ready = 1'b1;

	// Register file: hold values between writes, drop unknown indexes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha        <= emadl_pkg::ALPHA_RST;
			cfg_q.left_scale   <= emadl_pkg::LEFT_SCALE_RST;
			cfg_q.left_offset  <= emadl_pkg::LEFT_OFFSET_RST;
			cfg_q.right_scale  <= emadl_pkg::RIGHT_SCALE_RST;
			cfg_q.right_offset <= emadl_pkg::RIGHT_OFFSET_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				emadl_pkg::REG_ALPHA: begin
					cfg_q.alpha <= cfg_data[emadl_pkg::ALPHA_W-1:0];
				end
				emadl_pkg::REG_LEFT_SCALE: begin
					cfg_q.left_scale <= cfg_data[emadl_pkg::SCALE_W-1:0];
				end
				emadl_pkg::REG_LEFT_OFFSET: begin
					cfg_q.left_offset <= cfg_data[emadl_pkg::LEVEL_W-1:0];
				end
				emadl_pkg::REG_RIGHT_SCALE: begin
					cfg_q.right_scale <= cfg_data[emadl_pkg::SCALE_W-1:0];
				end
				emadl_pkg::REG_RIGHT_OFFSET: begin
					cfg_q.right_offset <= cfg_data[emadl_pkg::LEVEL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Smooth and classify.
	emadl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.side       (side),
		.sample     (sample),
		.push       (push),
		.push_job   (push_job),
		.queue_full (queue_full)
	);

	// Decouple the front end from the divider.
	emadl_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (queue_full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (queue_empty)
	);

	// Divide, saturate and present the result.
	emadl_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.pop_job     (pop_job),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.side_out    (side_out),
		.distance    (distance),
		.valid_res   (valid_res),
		.saturated   (saturated)
	);

endmodule

FILE: tb/ema_ir_distance_linearizer_check.sv
// Result checker for the distance linearizer: mirrors its smoothing and divide and compares.
`timescale 1ns / 1ps

module ema_ir_distance_linearizer_check (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic                             side,
	input  logic [emadl_pkg::SAMPLE_W-1:0]   sample,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic                             side_out,
	input  logic [emadl_pkg::DIST_W-1:0]     distance,
	input  logic                             valid_res,
	input  logic                             saturated,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [emadl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [emadl_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                               mismatches,
	output int                               outstanding
);

	localparam logic [63:0] DIST_LIMIT = 64'd65535;

	typedef struct packed {
		logic                         side;
		logic [emadl_pkg::DIST_W-1:0] distance;
		logic                         valid_res;
		logic                         saturated;
	} reading_t;

	emadl_pkg::cfg_t               regs;
	logic [emadl_pkg::LEVEL_W-1:0] level [2];
	reading_t                      readings_due [$];
	reading_t                      want;

	task automatic report(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [emadl_pkg::DIST_W-1:0] got,
			input logic [emadl_pkg::DIST_W-1:0] exp_val);
		if (got !== exp_val)
			report($sformatf("%s got %0d, want %0d", name, got, exp_val));
	endtask

	// Smooth the channel level, then divide the scaled numerator by its excess.
	task automatic predict_reading(input logic ch,
			input logic [emadl_pkg::SAMPLE_W-1:0] smp);
		logic [63:0]                   acc;
		logic [63:0]                   quot;
		logic [emadl_pkg::LEVEL_W-1:0] lvl;
		logic [emadl_pkg::LEVEL_W-1:0] off;
		logic [emadl_pkg::LEVEL_W-1:0] excess;
		logic [emadl_pkg::SCALE_W-1:0] scl;
		reading_t                      r;
		off = ch ? regs.right_offset : regs.left_offset;
		scl = ch ? regs.right_scale : regs.left_scale;
		acc = 64'(level[ch]) * (64'd65536 - 64'(regs.alpha))
			+ (64'(smp) << emadl_pkg::FRAC_W) * 64'(regs.alpha) + 64'd32768;
		lvl = acc[emadl_pkg::FRAC_W +: emadl_pkg::LEVEL_W];
		level[ch] = lvl;
		r = '{side: ch, distance: '0, valid_res: 1'b0, saturated: 1'b0};
		if (lvl > off) begin
			excess = lvl - off;
			quot = (64'(scl) << emadl_pkg::DIST_FRAC_W) / 64'(excess);
			r.valid_res = 1'b1;
			if (quot > DIST_LIMIT) begin
				r.distance = '1;
				r.saturated = 1'b1;
			end else begin
				r.distance = quot[emadl_pkg::DIST_W-1:0];
			end
		end
		readings_due.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = '{alpha: emadl_pkg::ALPHA_RST, left_scale: emadl_pkg::LEFT_SCALE_RST,
				left_offset: emadl_pkg::LEFT_OFFSET_RST,
				right_scale: emadl_pkg::RIGHT_SCALE_RST,
				right_offset: emadl_pkg::RIGHT_OFFSET_RST};
			level[0] = '0;
			level[1] = '0;
			readings_due.delete();
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					emadl_pkg::REG_ALPHA:
						regs.alpha = cfg_data[emadl_pkg::ALPHA_W-1:0];
					emadl_pkg::REG_LEFT_SCALE:
						regs.left_scale = cfg_data[emadl_pkg::SCALE_W-1:0];
					emadl_pkg::REG_LEFT_OFFSET:
						regs.left_offset = cfg_data[emadl_pkg::LEVEL_W-1:0];
					emadl_pkg::REG_RIGHT_SCALE:
						regs.right_scale = cfg_data[emadl_pkg::SCALE_W-1:0];
					emadl_pkg::REG_RIGHT_OFFSET:
						regs.right_offset = cfg_data[emadl_pkg::LEVEL_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_reading(side, sample);
			if (out_valid && !out_stall) begin
				if (readings_due.size() == 0) begin
					report("result with no item waiting for it");
				end else begin
					want = readings_due.pop_front();
					check_field("side_out", emadl_pkg::DIST_W'(side_out),
						emadl_pkg::DIST_W'(want.side));
					check_field("distance", distance, want.distance);
					check_field("valid_res", emadl_pkg::DIST_W'(valid_res),
						emadl_pkg::DIST_W'(want.valid_res));
					check_field("saturated", emadl_pkg::DIST_W'(saturated),
						emadl_pkg::DIST_W'(want.saturated));
				end
			end
			outstanding = readings_due.size();
		end
	end

endmodule

FILE: tb/ema_ir_distance_linearizer_tb.sv
// Top of the distance linearizer bench: clock, reset, stimulus, sink and verdict.
`timescale 1ns / 1ps

module ema_ir_distance_linearizer_tb;

	// Indexes past the register list; writes there must be dropped.
	localparam logic [emadl_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [emadl_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	// Cycles the sink holds off to back the block up into its input.
	localparam int LONG_HOLD    = 500;
	// Cycles to watch for stray results once everything has come back.
	localparam int TAIL_CYCLES  = 60;
	localparam int RANDOM_ITEMS = 130;
	localparam int RANDOM_PHASES = 7;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	logic                             side = 1'b0;
	logic [emadl_pkg::SAMPLE_W-1:0]   sample = '0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic                             side_out;
	logic [emadl_pkg::DIST_W-1:0]     distance;
	logic                             valid_res;
	logic                             saturated;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [emadl_pkg::CFG_IDX_W-1:0]  cfg_index = emadl_pkg::REG_ALPHA;
	logic [emadl_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// When set, both sides stop idling so items go back to back.
	logic calm = 1'b0;

	int mismatches;
	int outstanding;

	always #5 clk = ~clk;

	ema_ir_distance_linearizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.side      (side),
		.sample    (sample),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.side_out  (side_out),
		.distance  (distance),
		.valid_res (valid_res),
		.saturated (saturated),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ema_ir_distance_linearizer_check checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.side        (side),
		.sample      (sample),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.side_out    (side_out),
		.distance    (distance),
		.valid_res   (valid_res),
		.saturated   (saturated),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Offer one item after a random gap; return at the falling edge after it is taken.
	// With no gap, valid stays high and only the payload moves on.
	task automatic offer_sample(input logic ch, input logic [emadl_pkg::SAMPLE_W-1:0] value);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		side     <= ch;
		sample   <= value;
		do @(posedge clk); while (!(in_valid && !in_stall));
		@(negedge clk);
	endtask

	// Drop valid and hold until every predicted result has been returned.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	// Write one register; leave a cycle with valid low before the next write.
	task automatic write_reg(input logic [emadl_pkg::CFG_IDX_W-1:0] idx,
			input logic [emadl_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Load all five registers, plus a junk write to an unused index that must not land.
	task automatic apply_settings(input logic [emadl_pkg::CFG_DATA_W-1:0] alpha,
			input logic [emadl_pkg::CFG_DATA_W-1:0] l_scale,
			input logic [emadl_pkg::CFG_DATA_W-1:0] l_off,
			input logic [emadl_pkg::CFG_DATA_W-1:0] r_scale,
			input logic [emadl_pkg::CFG_DATA_W-1:0] r_off);
		write_reg(emadl_pkg::REG_ALPHA, alpha);
		write_reg(emadl_pkg::REG_LEFT_SCALE, l_scale);
		write_reg(emadl_pkg::REG_LEFT_OFFSET, l_off);
		write_reg(emadl_pkg::REG_RIGHT_SCALE, r_scale);
		write_reg(emadl_pkg::REG_RIGHT_OFFSET, r_off);
		write_reg(emadl_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
			$urandom());
	endtask

	function automatic logic [emadl_pkg::CFG_DATA_W-1:0] pick_scale();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2:       return $urandom_range(0, 65535);
			default: return $urandom();
		endcase
	endfunction

	// Offsets are taken modulo the level width, so the upper data bits are noise.
	function automatic logic [emadl_pkg::CFG_DATA_W-1:0] pick_offset();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return {6'($urandom_range(0, 63)), 26'h3FFFFFF};
			default: return $urandom();
		endcase
	endfunction

	// Alpha uses the low 16 bits; big weights move the level fast enough to cross offsets.
	function automatic logic [emadl_pkg::CFG_DATA_W-1:0] pick_alpha();
		logic [emadl_pkg::ALPHA_W-1:0] a;
		case ($urandom_range(0, 6))
			0:       a = 16'hFFFF;
			1:       a = 16'd1;
			2:       a = '0;
			3:       a = emadl_pkg::ALPHA_RST;
			4:       a = 16'($urandom_range(0, 65535));
			default: a = 16'($urandom_range(16384, 65535));
		endcase
		return {16'($urandom()), a};
	endfunction

	// Send runs of items on one channel around one level, so the average settles
	// there, with a share of stray samples mixed in.
	task automatic run_bursts(input int count);
		int                             sent;
		int                             burst;
		logic                           ch;
		logic [emadl_pkg::SAMPLE_W-1:0] target;
		logic [emadl_pkg::SAMPLE_W-1:0] value;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 8);
			ch = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 5))
				0:       target = '0;
				1:       target = '1;
				2:       target = emadl_pkg::SAMPLE_W'($urandom_range(0, 31));
				default: target = emadl_pkg::SAMPLE_W'($urandom_range(0, 1023));
			endcase
			for (int k = 0; k < burst && sent < count; k++) begin
				if ($urandom_range(0, 3) == 0)
					value = emadl_pkg::SAMPLE_W'($urandom_range(0, 1023));
				else
					value = target ^ emadl_pkg::SAMPLE_W'($urandom_range(0, 7));
				offer_sample(ch, value);
				sent++;
			end
		end
	endtask

	// Sink: stall for a random gap before each result; twice, hold off for a long
	// stretch while the sender keeps going, so the queue fills and the input stalls.
	initial begin : sink
		int wait_cycles;
		int taken;
		taken = 0;
		@(negedge clk);
		forever begin
			if (taken == 100 || taken == 700)
				wait_cycles = LONG_HOLD;
			else
				wait_cycles = calm ? 0 : $urandom_range(0, 4);
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
			taken++;
			@(negedge clk);
		end
	end

	// Stimulus and verdict.
	initial begin : stimulus
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings, slow weight: the level climbs from zero, so the first
		// results sit at or below the offset and later ones cross it.
		offer_sample(1'b0, 10'd0);
		repeat (6) offer_sample(1'b0, 10'd1023);
		repeat (5) offer_sample(1'b1, 10'd1023);
		offer_sample(1'b1, 10'd0);
		offer_sample(1'b0, 10'd512);
		run_bursts(100);

		// Full weight. Left: zero scale, zero offset, so a level of zero is invalid and
		// anything above gives distance zero. Right: top scale and top offset, never valid.
		wait_drained();
		apply_settings(32'h0000FFFF, 32'd0, 32'd0, 32'hFFFFFFFF, 32'h03FFFFFF);
		offer_sample(1'b0, 10'd0);
		offer_sample(1'b0, 10'd1023);
		offer_sample(1'b1, 10'd1023);
		offer_sample(1'b1, 10'd0);

		// Zero weight freezes both levels. Right sits just above zero with top scale,
		// so its quotient clips; left gets the smallest nonzero scale.
		wait_drained();
		apply_settings(32'hFFFF0000, 32'd1, 32'd0, 32'hFFFFFFFF, 32'd0);
		offer_sample(1'b1, 10'd1023);
		offer_sample(1'b1, 10'd0);
		offer_sample(1'b0, 10'd0);
		offer_sample(1'b0, 10'd1023);

		// Random settings per phase; one phase runs with no idling at all.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_drained();
			calm = (ph == 2);
			apply_settings(pick_alpha(), pick_scale(), pick_offset(), pick_scale(),
				pick_offset());
			run_bursts(RANDOM_ITEMS);
		end

		// Drain, then watch a while for anything extra.
		calm = 1'b0;
		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Hard stop well past the slowest correct run.
	initial begin : watchdog
		#4_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
